>>> rtl/tmli_pkg.sv
// ----------------------------------------------------------------------------
// tmli_pkg
// Shared types and codes for the triangle mesh linear interpolator.
// ----------------------------------------------------------------------------
package tmli_pkg;

  localparam logic [1:0] CMD_NODE   = 2'd0;
  localparam logic [1:0] CMD_CORNER = 2'd1;
  localparam logic [1:0] CMD_COEF   = 2'd2;
  localparam logic [1:0] CMD_EVAL   = 2'd3;

  localparam int CORNERS = 3;
  localparam int COEFS   = 3 * 3;

  typedef logic signed [31:0] q_t;

  // store write request, taken at input accept
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [9:0]  index;
    logic [3:0]  slot;
    q_t          value;
  } wr_req_t;

endpackage

>>> rtl/tmli_store.sv
// ----------------------------------------------------------------------------
// tmli_store
// Mesh memories: per-slot coefficient and corner banks read by triangle,
// then three node value copies read by the registered corner indices in the cycle after.
// ----------------------------------------------------------------------------
module tmli_store #(
  parameter int MAX_NODES     = 1024,
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic              clk,
  input  tmli_pkg::wr_req_t req,
  output tmli_pkg::q_t      coef_rd [tmli_pkg::COEFS],
  output tmli_pkg::q_t      node_rd [tmli_pkg::CORNERS]
);

  localparam int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int NA = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [31:0]   idx_ext;
  logic          tri_ok;
  logic          node_ok;
  logic [TA-1:0] tri_addr;
  logic [NA-1:0] node_waddr;

  assign idx_ext    = 32'(req.index);
  assign tri_ok     = idx_ext < 32'(MAX_TRIANGLES);
  assign node_ok    = idx_ext < 32'(MAX_NODES);
  assign tri_addr   = idx_ext[TA-1:0];
  assign node_waddr = idx_ext[NA-1:0];

  logic [9:0]   corner_r [tmli_pkg::CORNERS];
  tmli_pkg::q_t node_r   [tmli_pkg::CORNERS];
  logic         nok_r    [tmli_pkg::CORNERS];

  for (genvar k = 0; k < tmli_pkg::COEFS; k++) begin : g_coef
    tmli_pkg::q_t cmem [MAX_TRIANGLES];
    always_ff @(posedge clk) begin
      if (req.valid && req.cmd == tmli_pkg::CMD_COEF && tri_ok && req.slot == 4'(k)) begin
        cmem[tri_addr] <= req.value;
      end
      coef_rd[k] <= cmem[tri_addr];
    end
  end

  for (genvar k = 0; k < tmli_pkg::CORNERS; k++) begin : g_corner
    logic [9:0]   cnmem [MAX_TRIANGLES];
    tmli_pkg::q_t nmem  [MAX_NODES];
    logic [31:0]  cext;
    assign cext = 32'(corner_r[k]);

    always_ff @(posedge clk) begin
      if (req.valid && req.cmd == tmli_pkg::CMD_CORNER && tri_ok && req.slot == 4'(k)) begin
        cnmem[tri_addr] <= req.value[9:0];
      end
      corner_r[k] <= cnmem[tri_addr];
    end

    // node copy per corner; read-before-write keeps request order
    always_ff @(posedge clk) begin
      if (req.valid && req.cmd == tmli_pkg::CMD_NODE && node_ok) begin
        nmem[node_waddr] <= req.value;
      end
      node_r[k] <= nmem[cext[NA-1:0]];
      nok_r[k]  <= cext < 32'(MAX_NODES);
    end

    assign node_rd[k] = nok_r[k] ? node_r[k] : '0;
  end

endmodule

>>> rtl/tmli_calc.sv
// ----------------------------------------------------------------------------
// tmli_calc
// Arithmetic pipeline: coefficient products, basis clip, node products,
// final sum and clip.
// ----------------------------------------------------------------------------
module tmli_calc (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         eval_in,
  input  logic         zero_in,
  input  tmli_pkg::q_t x_in,
  input  tmli_pkg::q_t y_in,
  input  tmli_pkg::q_t coef_rd [tmli_pkg::COEFS],
  input  tmli_pkg::q_t node_rd [tmli_pkg::CORNERS],
  output logic         res_valid,
  output tmli_pkg::q_t res_value,
  output logic         res_sat
);

  localparam int C = tmli_pkg::CORNERS;
  localparam logic signed [49:0] QMAX = 50'sd2147483647;
  localparam logic signed [49:0] QMIN = -50'sd2147483648;

  // stage 1: coefficients arrive
  logic         v1_r, z1_r;
  tmli_pkg::q_t x1_r, y1_r;
  // stage 2: x/y products, node values arrive
  logic              v2_r, z2_r;
  logic signed [63:0] px_r [C];
  logic signed [63:0] py_r [C];
  tmli_pkg::q_t       a0_r [C];
  // stage 3: clipped basis
  logic         v3_r, z3_r, s3_r;
  tmli_pkg::q_t b_r [C];
  tmli_pkg::q_t f_r [C];
  // stage 4: node products
  logic               v4_r, z4_r, s4_r;
  logic signed [63:0] q_r [C];

  logic signed [49:0] bsum [C];
  tmli_pkg::q_t       bclip [C];
  logic [C-1:0]       bsat;
  logic signed [49:0] tot;

  always_comb begin
    for (int c = 0; c < C; c++) begin
      bsum[c] = 50'(a0_r[c]) + 50'(px_r[c] >>> 16) + 50'(py_r[c] >>> 16);
      bsat[c] = (bsum[c] > QMAX) || (bsum[c] < QMIN);
      if (bsum[c] > QMAX) begin
        bclip[c] = 32'sh7fffffff;
      end else if (bsum[c] < QMIN) begin
        bclip[c] = 32'sh80000000;
      end else begin
        bclip[c] = bsum[c][31:0];
      end
    end
    tot = 50'(q_r[0] >>> 16) + 50'(q_r[1] >>> 16) + 50'(q_r[2] >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= eval_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= zero_in;
    x1_r <= x_in;
    y1_r <= y_in;
    z2_r <= z1_r;
    for (int c = 0; c < C; c++) begin
      px_r[c] <= coef_rd[3*c+1] * 64'(x1_r);
      py_r[c] <= coef_rd[3*c+2] * 64'(y1_r);
      a0_r[c] <= coef_rd[3*c];
      b_r[c]  <= bclip[c];
      f_r[c]  <= node_rd[c];
      q_r[c]  <= 64'(f_r[c]) * 64'(b_r[c]);
    end
    z3_r <= z2_r;
    s3_r <= |bsat;
    z4_r <= z3_r;
    s4_r <= s3_r;
  end

  assign res_valid = v4_r;

  always_comb begin
    if (z4_r) begin
      res_value = '0;
      res_sat   = 1'b0;
    end else if (tot > QMAX) begin
      res_value = 32'sh7fffffff;
      res_sat   = 1'b1;
    end else if (tot < QMIN) begin
      res_value = 32'sh80000000;
      res_sat   = 1'b1;
    end else begin
      res_value = tot[31:0];
      res_sat   = s4_r;
    end
  end

endmodule

>>> rtl/tmli_ofifo.sv
// ----------------------------------------------------------------------------
// tmli_ofifo
// Result queue between the pipeline and the output channel.
// ----------------------------------------------------------------------------
module tmli_ofifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  tmli_pkg::q_t push_value,
  input  logic         push_sat,
  input  logic         pop,
  output logic         not_empty,
  output tmli_pkg::q_t head_value,
  output logic         head_sat
);

  logic [32:0] buf_r [8];
  logic [2:0]  wp_r, rp_r;
  logic [3:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= {push_sat, push_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 3'd1;
      if (pop)  rp_r <= rp_r + 3'd1;
      cnt_r <= cnt_r + 4'(push) - 4'(pop);
    end
  end

  assign not_empty  = cnt_r != 4'd0;
  assign head_value = buf_r[rp_r][31:0];
  assign head_sat   = buf_r[rp_r][32];

endmodule

>>> rtl/triangle_mesh_linear_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_mesh_linear_interpolator
// Piecewise linear interpolation over a stored triangle mesh, Q16.16.
// ----------------------------------------------------------------------------
// Input channel in_*: one request per accepted beat. in_tuser holds the cmd
// (node load, corner load, coefficient load, evaluate). Loads write the mesh
// memories and give no result; an evaluate gives exactly one result on out_*.
// Throughput: one request per cycle while in_tready is high, loads and evaluates mixed freely.
// An evaluate's result shows on out_tvalid after the registered memory reads
// (triangle row, then node values), the two multiply stages and the write
// into the result queue.
// Up to 8 evaluates may be outstanding; the 8-entry result queue absorbs
// them, so a stalled receiver holds in_tready low only once 8 results wait
// or are in flight. Loads are held back with them to keep order simple.
// Reset clears the pipeline, queue and credit counter; the mesh memories
// are not cleared and must be loaded before they are evaluated.
// ----------------------------------------------------------------------------
module triangle_mesh_linear_interpolator #(
  parameter int MAX_NODES     = 1024,
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [9:0] index, [13:10] slot, [45:14] load_value, [77:46] point_x,
  // [109:78] point_y, [110] inside_mesh, [111] unused
  input  logic [111:0] in_tdata,
  // [1:0] cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] interpolated
  output logic [31:0]  out_tdata,
  // [0] saturated
  output logic         out_tuser
);

  localparam logic [3:0] CREDITS = 4'd8;

  logic              in_acc, eval_acc, out_acc, zero_in;
  logic [3:0]        cnt_r;
  tmli_pkg::wr_req_t req;
  tmli_pkg::q_t      coef_rd [tmli_pkg::COEFS];
  tmli_pkg::q_t      node_rd [tmli_pkg::CORNERS];
  logic              res_valid, res_sat, head_sat;
  tmli_pkg::q_t      res_value, head_value;

  assign in_tready = cnt_r != CREDITS;
  assign in_acc    = in_tvalid && in_tready;
  assign eval_acc  = in_acc && in_tuser == tmli_pkg::CMD_EVAL;
  assign out_acc   = out_tvalid && out_tready;

  assign req.valid = in_acc;
  assign req.cmd   = in_tuser;
  assign req.index = in_tdata[9:0];
  assign req.slot  = in_tdata[13:10];
  assign req.value = in_tdata[45:14];

  assign zero_in = !in_tdata[110] || (32'(in_tdata[9:0]) >= 32'(MAX_TRIANGLES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 4'(eval_acc) - 4'(out_acc);
    end
  end

  tmli_store #(
    .MAX_NODES    (MAX_NODES),
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_store (
    .clk    (clk),
    .req    (req),
    .coef_rd(coef_rd),
    .node_rd(node_rd)
  );

  tmli_calc u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .eval_in  (eval_acc),
    .zero_in  (zero_in),
    .x_in     (in_tdata[77:46]),
    .y_in     (in_tdata[109:78]),
    .coef_rd  (coef_rd),
    .node_rd  (node_rd),
    .res_valid(res_valid),
    .res_value(res_value),
    .res_sat  (res_sat)
  );

  tmli_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_value(res_value),
    .push_sat  (res_sat),
    .pop       (out_acc),
    .not_empty (out_tvalid),
    .head_value(head_value),
    .head_sat  (head_sat)
  );

  assign out_tdata = head_value;
  assign out_tuser = head_sat;

  a_credit_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CREDITS)
    else $error("credit counter overflow");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != 4'd0)
    else $error("result without outstanding evaluate");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CREDITS) |-> !in_acc)
    else $error("request accepted with no credit");

  a_res_needs_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> cnt_r != 4'd0)
    else $error("pipeline result without credit");

endmodule
